// File: sv/tpc_pkg.sv
// tpc_pkg: types, constants and the clip plan function for the triangle plane clipper
// no dependencies; compiled first
`default_nettype none
package tpc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NFIELD        = 6;
	localparam int NVTX          = 3;
	localparam int DW            = 54;      // signed plane distance
	localparam int NW            = DW + 2;  // divider remainder
	localparam int AW            = 5;       // apb address bits

	localparam logic [2:0] REG_PX = 3'd0;
	localparam logic [2:0] REG_PY = 3'd1;
	localparam logic [2:0] REG_PZ = 3'd2;
	localparam logic [2:0] REG_NX = 3'd3;
	localparam logic [2:0] REG_NY = 3'd4;
	localparam logic [2:0] REG_NZ = 3'd5;

	typedef enum logic [2:0] {
		SRC_V0 = 3'd0,
		SRC_V1 = 3'd1,
		SRC_V2 = 3'd2,
		SRC_X0 = 3'd3,
		SRC_X1 = 3'd4
	} src_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIST = 6'b000010,
		ST_PLAN = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	typedef struct packed {
		logic [NFIELD-1:0][31:0] f;   // pos x, y, z, tex u, v, w
		logic [23:0]             colour;
	} vtx_t;

	typedef struct packed {
		logic [2:0][31:0] point;
		logic [2:0][17:0] normal;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       n_out;
		logic             need_cut;
		src_t [5:0]       src;
		logic [1:0][1:0]  cut_a;
		logic [1:0][1:0]  cut_b;
	} plan_t;

	typedef struct packed {
		logic       load;
		logic [1:0] vidx;
		logic       dist_mul;
		logic [1:0] axis;
		logic       dist_acc;
		logic       div_init;
		logic       div_step;
		logic [1:0] cut_a;
		logic [1:0] cut_b;
		logic       cj;
		logic       int_mul;
		logic [2:0] field;
		logic       int_wr;
		logic [2:0] wfield;
		src_t       out_src;
	} cmd_t;

	typedef struct packed {
		logic [2:0] is_in;
	} status_t;

	function automatic src_t vsrc(logic [1:0] i);
		return src_t'({1'b0, i});
	endfunction

	function automatic plan_t make_plan(logic [2:0] is_in);
		plan_t      p;
		logic [1:0] i0, i1, o0, o1;
		logic [1:0] ni;
		p  = '0;
		ni = 2'(is_in[0]) + 2'(is_in[1]) + 2'(is_in[2]);
		i0 = is_in[0] ? 2'd0 : (is_in[1] ? 2'd1 : 2'd2);
		i1 = is_in[2] ? 2'd2 : 2'd1;
		o0 = !is_in[0] ? 2'd0 : (!is_in[1] ? 2'd1 : 2'd2);
		o1 = !is_in[2] ? 2'd2 : 2'd1;
		for (int k = 0; k < 6; k++) p.src[k] = SRC_V0;
		if (is_in == 3'b111) begin
			p.n_out  = 3'd3;
			p.src[0] = SRC_V0;
			p.src[1] = SRC_V1;
			p.src[2] = SRC_V2;
		end else if (ni == 2'd1) begin
			p.n_out    = 3'd3;
			p.need_cut = 1'b1;
			p.cut_a[0] = i0;
			p.cut_b[0] = o0;
			p.cut_a[1] = i0;
			p.cut_b[1] = o1;
			p.src[0]   = vsrc(i0);
			p.src[1]   = SRC_X0;
			p.src[2]   = SRC_X1;
		end else if (ni == 2'd2) begin
			p.n_out    = 3'd6;
			p.need_cut = 1'b1;
			p.cut_a[0] = i0;
			p.cut_b[0] = o0;
			p.cut_a[1] = i1;
			p.cut_b[1] = o0;
			p.src[0]   = vsrc(i0);
			p.src[1]   = vsrc(i1);
			p.src[2]   = SRC_X0;
			p.src[3]   = vsrc(i1);
			p.src[4]   = SRC_X0;
			p.src[5]   = SRC_X1;
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// File: sv/tpc_in_if.sv
// tpc_in_if: valid/ready channel carrying one input vertex
// no dependencies
`default_nettype none
interface tpc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] in_pos_x;
	logic [31:0] in_pos_y;
	logic [31:0] in_pos_z;
	logic [31:0] in_tex_u;
	logic [31:0] in_tex_v;
	logic [31:0] in_tex_w;
	logic [23:0] in_colour;

	modport source (output valid, in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v,
		in_tex_w, in_colour, input ready);
	modport sink (input valid, in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v,
		in_tex_w, in_colour, output ready);
endinterface
`default_nettype wire

// File: sv/tpc_out_if.sv
// tpc_out_if: valid/ready channel carrying one clipped output vertex
// no dependencies
`default_nettype none
interface tpc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pos_x;
	logic [31:0] out_pos_y;
	logic [31:0] out_pos_z;
	logic [31:0] out_tex_u;
	logic [31:0] out_tex_v;
	logic [31:0] out_tex_w;
	logic [23:0] out_colour;
	logic        out_last;

	modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
		out_tex_w, out_colour, out_last, input ready);
	modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
		out_tex_w, out_colour, out_last, output ready);
endinterface
`default_nettype wire

// File: sv/tpc_cfg.sv
// tpc_cfg: apb register file holding the clip plane point and normal
// depends on tpc_pkg
`default_nettype none
module tpc_cfg (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [tpc_pkg::AW-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output tpc_pkg::cfg_t              cfg
);
	import tpc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;

	assign idx    = paddr[AW-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.point  <= '0;
			cfg_q.normal <= {18'd65536, 18'd0, 18'd0};
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_PX: cfg_q.point[0]  <= pwdata;
				REG_PY: cfg_q.point[1]  <= pwdata;
				REG_PZ: cfg_q.point[2]  <= pwdata;
				REG_NX: cfg_q.normal[0] <= pwdata[17:0];
				REG_NY: cfg_q.normal[1] <= pwdata[17:0];
				REG_NZ: cfg_q.normal[2] <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PX:  prdata = cfg_q.point[0];
			REG_PY:  prdata = cfg_q.point[1];
			REG_PZ:  prdata = cfg_q.point[2];
			REG_NX:  prdata = {{14{cfg_q.normal[0][17]}}, cfg_q.normal[0]};
			REG_NY:  prdata = {{14{cfg_q.normal[1][17]}}, cfg_q.normal[1]};
			REG_NZ:  prdata = {{14{cfg_q.normal[2][17]}}, cfg_q.normal[2]};
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/tpc_dp.sv
// tpc_dp: vertex registers, distance multiply-accumulate, restoring divider and
// edge interpolation; driven by tpc_ctrl commands, depends on tpc_pkg
`default_nettype none
module tpc_dp #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire tpc_pkg::cfg_t    cfg,
	input  wire tpc_pkg::vtx_t    in_vtx,
	input  wire tpc_pkg::cmd_t    cmd,
	output tpc_pkg::status_t      status,
	output tpc_pkg::vtx_t         out_vtx
);
	import tpc_pkg::*;

	localparam int PIW = 34 + FRAC_BITS;

	logic [31:0]          v_q [NVTX][NFIELD];
	logic [31:0]          x_q [2][NFIELD];
	logic [23:0]          colour_q;
	logic signed [DW-1:0] d_q [NVTX];
	logic signed [DW-1:0] prod_d_s1;
	logic [NW-1:0]        num_q, den_q;
	logic [FRAC_BITS-1:0] t_q;
	logic signed [PIW-1:0] prod_i_s1;

	logic signed [32:0]   ddiff, idiff;
	logic signed [17:0]   nsel;
	logic signed [50:0]   pd;
	logic signed [PIW-1:0] pi, sh;
	logic signed [DW:0]   dd;
	logic [NW-1:0]        n2;
	logic                 ge;
	logic [31:0]          va, vb, vaw;

	always_comb begin
		nsel  = $signed(cfg.normal[cmd.axis]);
		ddiff = $signed({v_q[cmd.vidx][cmd.axis][31], v_q[cmd.vidx][cmd.axis]})
			- $signed({cfg.point[cmd.axis][31], cfg.point[cmd.axis]});
		pd    = nsel * ddiff;
		dd    = $signed({d_q[cmd.cut_a][DW-1], d_q[cmd.cut_a]})
			- $signed({d_q[cmd.cut_b][DW-1], d_q[cmd.cut_b]});
		n2    = {num_q[NW-2:0], 1'b0};
		ge    = n2 >= den_q;
		va    = v_q[cmd.cut_a][cmd.field];
		vb    = v_q[cmd.cut_b][cmd.field];
		idiff = $signed({vb[31], vb}) - $signed({va[31], va});
		pi    = idiff * $signed({1'b0, t_q});
		sh    = prod_i_s1 >>> FRAC_BITS;
		vaw   = v_q[cmd.cut_a][cmd.wfield];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int f = 0; f < NFIELD; f++) v_q[cmd.vidx][f] <= in_vtx.f[f];
			d_q[cmd.vidx] <= '0;
			if (cmd.vidx == 2'd2) colour_q <= in_vtx.colour;
		end
		if (cmd.dist_mul) prod_d_s1 <= DW'(pd);
		if (cmd.dist_acc) d_q[cmd.vidx] <= d_q[cmd.vidx] + prod_d_s1;
		if (cmd.div_init) begin
			num_q <= {2'b00, d_q[cmd.cut_a]};
			den_q <= {1'b0, dd};
			t_q   <= '0;
		end else if (cmd.div_step) begin
			num_q <= ge ? n2 - den_q : n2;
			t_q   <= {t_q[FRAC_BITS-2:0], ge};
		end
		if (cmd.int_mul) prod_i_s1 <= pi;
		if (cmd.int_wr) x_q[cmd.cj][cmd.wfield] <= vaw + sh[31:0];
	end

	// zero distance counts as inside
	always_comb begin
		for (int i = 0; i < NVTX; i++) status.is_in[i] = !d_q[i][DW-1];
	end

	always_comb begin
		out_vtx.colour = colour_q;
		for (int f = 0; f < NFIELD; f++) begin
			case (cmd.out_src)
				SRC_V0:  out_vtx.f[f] = v_q[0][f];
				SRC_V1:  out_vtx.f[f] = v_q[1][f];
				SRC_V2:  out_vtx.f[f] = v_q[2][f];
				SRC_X0:  out_vtx.f[f] = x_q[0][f];
				SRC_X1:  out_vtx.f[f] = x_q[1][f];
				default: out_vtx.f[f] = v_q[0][f];
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/tpc_ctrl.sv
// tpc_ctrl: sequencer for load, distance, plan, divide, interpolate and emit
// depends on tpc_pkg; commands tpc_dp
`default_nettype none
module tpc_ctrl #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  out_last,
	input  wire tpc_pkg::status_t status,
	output tpc_pkg::cmd_t         cmd
);
	import tpc_pkg::*;

	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [CW-1:0] DIV_LAST = CW'(FRAC_BITS);
	localparam logic [CW-1:0] MAC_LAST = CW'(3);
	localparam logic [CW-1:0] MUL_LAST = CW'(NFIELD);

	state_t      state_q;
	logic [1:0]  phase_q, vidx_q;
	logic [CW-1:0] cnt_q;
	logic        cj_q;
	plan_t       plan_q, plan_c;
	logic [2:0]  eidx_q;
	logic [1:0]  vidx_c;

	assign plan_c   = make_plan(status.is_in);
	assign vidx_c   = phase_q[1] ? 2'd2 : {1'b0, phase_q[0]};
	assign in_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_EMIT;
	assign out_last = eidx_q == plan_q.n_out - 3'd1;

	always_comb begin
		cmd          = '0;
		cmd.vidx     = in_ready ? vidx_c : vidx_q;
		cmd.axis     = cnt_q[1:0];
		cmd.cut_a    = plan_q.cut_a[cj_q];
		cmd.cut_b    = plan_q.cut_b[cj_q];
		cmd.cj       = cj_q;
		cmd.field    = cnt_q[2:0];
		cmd.wfield   = cnt_q[2:0] - 3'd1;
		cmd.out_src  = plan_q.src[eidx_q];
		cmd.load     = in_ready && in_valid;
		cmd.dist_mul = state_q == ST_DIST && cnt_q != MAC_LAST;
		cmd.dist_acc = state_q == ST_DIST && cnt_q != '0;
		cmd.div_init = state_q == ST_DIV && cnt_q == '0;
		cmd.div_step = state_q == ST_DIV && cnt_q != '0;
		cmd.int_mul  = state_q == ST_MUL && cnt_q != MUL_LAST;
		cmd.int_wr   = state_q == ST_MUL && cnt_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			vidx_q  <= '0;
			cnt_q   <= '0;
			cj_q    <= 1'b0;
			plan_q  <= '0;
			eidx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					vidx_q  <= vidx_c;
					phase_q <= phase_q[1] ? 2'd0 : phase_q + 2'd1;
					cnt_q   <= '0;
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == MAC_LAST) state_q <= (vidx_q == 2'd2) ? ST_PLAN : ST_IDLE;
				end
				ST_PLAN: begin
					plan_q <= plan_c;
					cnt_q  <= '0;
					cj_q   <= 1'b0;
					eidx_q <= '0;
					if (plan_c.n_out == 3'd0) state_q <= ST_IDLE;
					else if (plan_c.need_cut) state_q <= ST_DIV;
					else state_q <= ST_EMIT;
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						cnt_q   <= '0;
						cj_q    <= 1'b1;
						state_q <= cj_q ? ST_EMIT : ST_DIV;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_EMIT: if (out_ready) begin
					eidx_q <= eidx_q + 3'd1;
					if (out_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/triangle_plane_clipper.sv
// Triangle plane clipper: vertices enter one per transaction; the first two of each
// triangle are held and give nothing, the third completes it and 0, 3 or 6 vertices
// leave, the last one flagged by out_last. Every vertex is taken in the accepting cycle
// and then goes through the distance multiply-accumulate (one multiply per axis). A
// completed triangle then passes a plan step and, for each cut edge, the restoring
// divider and the interpolation multiplier, followed by one emitted vertex per cycle
// while the sink is ready. Plane registers (APB, byte address 4*index) must be
// written while idle and between triangles.
// depends on tpc_pkg, tpc_in_if, tpc_out_if, tpc_cfg, tpc_ctrl, tpc_dp
`default_nettype none
module triangle_plane_clipper #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	tpc_in_if.sink                      vin,
	tpc_out_if.source                   vout,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [tpc_pkg::AW-1:0] paddr,
	input  wire logic [31:0]            pwdata,
	output logic      [31:0]            prdata,
	output logic                        pready
);
	import tpc_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	vtx_t    in_vtx, out_vtx;

	assign in_vtx.f[0]   = vin.in_pos_x;
	assign in_vtx.f[1]   = vin.in_pos_y;
	assign in_vtx.f[2]   = vin.in_pos_z;
	assign in_vtx.f[3]   = vin.in_tex_u;
	assign in_vtx.f[4]   = vin.in_tex_v;
	assign in_vtx.f[5]   = vin.in_tex_w;
	assign in_vtx.colour = vin.in_colour;

	assign vout.out_pos_x  = out_vtx.f[0];
	assign vout.out_pos_y  = out_vtx.f[1];
	assign vout.out_pos_z  = out_vtx.f[2];
	assign vout.out_tex_u  = out_vtx.f[3];
	assign vout.out_tex_v  = out_vtx.f[4];
	assign vout.out_tex_w  = out_vtx.f[5];
	assign vout.out_colour = out_vtx.colour;

	tpc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	tpc_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(vin.valid), .in_ready(vin.ready),
		.out_valid(vout.valid), .out_ready(vout.ready), .out_last(vout.out_last),
		.status(status), .cmd(cmd)
	);

	tpc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .cfg(cfg), .in_vtx(in_vtx), .cmd(cmd), .status(status),
		.out_vtx(out_vtx)
	);
endmodule
`default_nettype wire

// File: dv/tb_tpc_if.sv
// tb_tpc_if: clock generator for the testbench; the channels use the rtl interfaces
// depends on nothing
`default_nettype none
module tb_tpc_clk_gen (
	output logic clk
);
	timeunit 1ns;
	timeprecision 1ps;
	initial clk = 1'b0;
	always #5 clk = ~clk;
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking testbench for triangle_plane_clipper
// depends on tpc_pkg, tpc_in_if, tpc_out_if, the clipper rtl and tb_tpc_clk_gen
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tpc_pkg::*;

	localparam int FB = 16;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [31:0] f [6];
		logic [23:0] colour;
	} vert_t;

	typedef struct {
		logic [31:0] f [6];
		logic [23:0] colour;
		logic        last;
	} clip_vert_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	tpc_in_if  vin ();
	tpc_out_if vout ();

	tb_tpc_clk_gen u_clk (.clk(clk));

	triangle_plane_clipper DUT (
		.clk(clk), .arst_n(arst_n), .vin(vin), .vout(vout),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic signed [31:0] plane_pt [3];
	logic signed [17:0] plane_n [3];
	int unsigned held_cnt;
	vert_t held [2];

	clip_vert_t clip_q [$];
	int n_err, n_out, n_tri, n_clipped;
	longint cyc;
	logic rx_hold;
	logic all_sent;

	function automatic longint plane_dist(vert_t v);
		longint a;
		a = 0;
		for (int i = 0; i < 3; i++)
			a += longint'(plane_n[i]) * (longint'($signed(v.f[i])) - longint'(plane_pt[i]));
		return a;
	endfunction

	function automatic vert_t crossing(vert_t a, longint da, vert_t b, longint db);
		vert_t r;
		longint unsigned num, den, t;
		longint diff, prod, sh;
		num = da;
		den = da - db;
		t = 0;
		for (int i = 0; i < FB; i++) begin
			num = num << 1;
			t = t << 1;
			if (num >= den) begin
				num -= den;
				t |= 1;
			end
		end
		for (int i = 0; i < 6; i++) begin
			diff = longint'($signed(b.f[i])) - longint'($signed(a.f[i]));
			prod = diff * longint'(t);
			sh = prod >>> FB;
			r.f[i] = 32'(longint'($signed(a.f[i])) + sh);
		end
		r.colour = '0;
		return r;
	endfunction

	task automatic push_vert(vert_t v, logic [23:0] col, logic last);
		clip_vert_t c;
		c.f = v.f;
		c.colour = col;
		c.last = last;
		clip_q = {clip_q, c};
	endtask

	// works out the vertices that leave for one accepted input vertex
	task automatic clip_predict(vert_t v);
		vert_t t [3];
		longint d [3];
		int ins [3];
		int outs [3];
		int cnt_in, cnt_out;
		vert_t x0, x1;
		cnt_in = 0;
		cnt_out = 0;
		if (held_cnt < 2) begin
			held[held_cnt[0]] = v;
			held_cnt++;
			return;
		end
		held_cnt = 0;
		n_tri++;
		t[0] = held[0];
		t[1] = held[1];
		t[2] = v;
		for (int i = 0; i < 3; i++) begin
			d[i] = plane_dist(t[i]);
			if (d[i] >= 0) begin
				ins[cnt_in] = i;
				cnt_in++;
			end else begin
				outs[cnt_out] = i;
				cnt_out++;
			end
		end
		if (cnt_in == 3) begin
			push_vert(t[0], v.colour, 1'b0);
			push_vert(t[1], v.colour, 1'b0);
			push_vert(t[2], v.colour, 1'b1);
		end else if (cnt_in == 1) begin
			n_clipped++;
			x0 = crossing(t[ins[0]], d[ins[0]], t[outs[0]], d[outs[0]]);
			x1 = crossing(t[ins[0]], d[ins[0]], t[outs[1]], d[outs[1]]);
			push_vert(t[ins[0]], v.colour, 1'b0);
			push_vert(x0, v.colour, 1'b0);
			push_vert(x1, v.colour, 1'b1);
		end else if (cnt_in == 2) begin
			n_clipped++;
			x0 = crossing(t[ins[0]], d[ins[0]], t[outs[0]], d[outs[0]]);
			x1 = crossing(t[ins[1]], d[ins[1]], t[outs[0]], d[outs[0]]);
			push_vert(t[ins[0]], v.colour, 1'b0);
			push_vert(t[ins[1]], v.colour, 1'b0);
			push_vert(x0, v.colour, 1'b0);
			push_vert(t[ins[1]], v.colour, 1'b0);
			push_vert(x0, v.colour, 1'b0);
			push_vert(x1, v.colour, 1'b1);
		end
	endtask

	task automatic idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return;
		vin.valid <= 1'b0;
		if (r < 93) repeat ($urandom_range(1, 4)) @(negedge clk);
		else repeat ($urandom_range(20, 80)) @(negedge clk);
	endtask

	// valid stays high after the transaction; a gap or a drain drops it
	task automatic send_vert(vert_t v);
		vin.valid <= 1'b1;
		vin.in_pos_x <= v.f[0];
		vin.in_pos_y <= v.f[1];
		vin.in_pos_z <= v.f[2];
		vin.in_tex_u <= v.f[3];
		vin.in_tex_v <= v.f[4];
		vin.in_tex_w <= v.f[5];
		vin.in_colour <= v.colour;
		do @(posedge clk); while (!vin.ready);
		clip_predict(v);
		@(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		if (idx < REG_NX) plane_pt[idx] = val;
		else plane_n[idx - REG_NX] = val[17:0];
	endtask

	task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [17:0] nx, logic [17:0] ny, logic [17:0] nz);
		reg_write(REG_PX, px);
		reg_write(REG_PY, py);
		reg_write(REG_PZ, pz);
		reg_write(REG_NX, 32'($signed(nx)));
		reg_write(REG_NY, 32'($signed(ny)));
		reg_write(REG_NZ, 32'($signed(nz)));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// every expected vertex out, then a latency allowance so the block is idle
	task automatic drain();
		vin.valid <= 1'b0;
		while (clip_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic vert_t rand_vert(int mode);
		vert_t v;
		for (int i = 0; i < 6; i++) begin
			case (mode)
				0: v.f[i] = $urandom();
				1: v.f[i] = 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
				default: v.f[i] = 32'($signed($urandom_range(0, 2 * 4096)) - 4096);
			endcase
		end
		v.colour = 24'($urandom());
		return v;
	endfunction

	function automatic vert_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] u, logic [23:0] c);
		vert_t v;
		v.f[0] = x; v.f[1] = y; v.f[2] = z;
		v.f[3] = u; v.f[4] = ~u; v.f[5] = u ^ 32'h5A5A_A5A5;
		v.colour = c;
		return v;
	endfunction

	// directed rows; expected output typed in for the plain pass-through triangle
	typedef struct {
		vert_t v;
		logic  chk_pass;
	} row_t;
	row_t dir_tab [12];

	// output checker
	always @(posedge clk) begin
		clip_vert_t e, a;
		logic bad;
		if (arst_n && vout.valid && vout.ready) begin
			a.f[0] = vout.out_pos_x; a.f[1] = vout.out_pos_y; a.f[2] = vout.out_pos_z;
			a.f[3] = vout.out_tex_u; a.f[4] = vout.out_tex_v; a.f[5] = vout.out_tex_w;
			a.colour = vout.out_colour;
			a.last = vout.out_last;
			n_out++;
			if (clip_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected output vertex x=%h last=%b", a.f[0], a.last);
			end else begin
				e = clip_q.pop_front();
				bad = (a.colour !== e.colour) || (a.last !== e.last);
				for (int i = 0; i < 6; i++) if (a.f[i] !== e.f[i]) bad = 1'b1;
				if (bad) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch @%0d exp %h %h %h %h %h %h %h %b got %h %h %h %h %h %h %h %b",
							cyc, e.f[0], e.f[1], e.f[2], e.f[3], e.f[4], e.f[5], e.colour, e.last,
							a.f[0], a.f[1], a.f[2], a.f[3], a.f[4], a.f[5], a.colour, a.last);
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n || rx_hold) vout.ready <= 1'b0;
		else if ($urandom_range(0, 99) < 8) vout.ready <= 1'b0;
		else if ($urandom_range(0, 99) < 80) vout.ready <= 1'b1;
	end

	initial begin
		int cnt;
		rx_hold = 1'b0;
		wait (all_sent === 1'b0);
		@(posedge clk);
		wait (n_tri >= 60);
		@(negedge clk);
		rx_hold = 1'b1;
		cnt = 0;
		while (cnt < 600) begin
			@(negedge clk);
			cnt++;
		end
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("triangle_plane_clipper verification failed");
			$finish;
		end
	end

	initial begin
		vert_t v;
		int mode;
		cyc = 0;
		n_err = 0; n_out = 0; n_tri = 0; n_clipped = 0;
		all_sent = 1'b0;
		held_cnt = 0;
		plane_pt = '{0, 0, 0};
		plane_n = '{0, 0, 18'sd65536};
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		vin.valid = 1'b0;
		vin.in_pos_x = '0; vin.in_pos_y = '0; vin.in_pos_z = '0;
		vin.in_tex_u = '0; vin.in_tex_v = '0; vin.in_tex_w = '0; vin.in_colour = '0;
		vout.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// after reset the plane is z = 0, inside towards +z
		dir_tab[0] = '{mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 24'h0), 1'b1};
		dir_tab[1] = '{mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			24'hFFFFFF), 1'b1};
		dir_tab[2] = '{mk(32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0, 24'hFFFFFF), 1'b1};
		// one inside, two outside
		dir_tab[3] = '{mk(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 24'h123456), 1'b0};
		dir_tab[4] = '{mk(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0, 24'h0), 1'b0};
		dir_tab[5] = '{mk(32'h0, 32'h0001_0000, 32'hFFFE_0000, 32'h0, 24'hABCDEF), 1'b0};
		// two inside, one outside, outside vertex first
		dir_tab[6] = '{mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			24'h0), 1'b0};
		dir_tab[7] = '{mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			24'h0), 1'b0};
		dir_tab[8] = '{mk(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 24'h00FF00), 1'b0};
		// all outside: nothing leaves
		dir_tab[9] = '{mk(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 24'h0), 1'b0};
		dir_tab[10] = '{mk(32'h0, 32'h0, 32'h8000_0000, 32'h0, 24'h0), 1'b0};
		dir_tab[11] = '{mk(32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 24'hFFFFFF), 1'b0};
		foreach (dir_tab[i]) begin
			send_vert(dir_tab[i].v);
			// pass-through triangles read straight off: same vertices, third colour
			if (dir_tab[i].chk_pass && i == 2) begin
				if (clip_q.size() < 3 || clip_q[0].f[0] !== 32'h7FFF_FFFF
					|| clip_q[2].colour !== 24'hFFFFFF || clip_q[2].last !== 1'b1) begin
					n_err++;
					$display("pass-through triangle prediction wrong");
				end
			end
		end
		drain();

		// zero normal: everything passes; extremes of the point registers
		set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 18'sd0, 18'sd0, 18'sd0);
		for (int i = 0; i < 6; i++) send_vert(rand_vert(0));
		drain();
		// non-unit normal extremes
		set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			-18'sd65536, 18'sd65536, -18'sd65536);
		for (int i = 0; i < 6; i++) send_vert(rand_vert(0));
		drain();

		// random phases, each with its own plane
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_plane('0, '0, '0, 18'sd65536, '0, '0);
				1: set_plane(32'h0001_8000, 32'hFFFF_0000, 32'h0, '0, -18'sd65536, '0);
				default: set_plane(32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536),
					32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536),
					32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536),
					18'($signed($urandom_range(0, 131072)) - 65536),
					18'($signed($urandom_range(0, 131072)) - 65536),
					18'($signed($urandom_range(0, 131072)) - 65536));
			endcase
			for (int i = 0; i < 63; i++) begin
				mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
				v = rand_vert(mode);
				if ($urandom_range(0, 19) == 0) v.f[2] = plane_pt[2];
				if (ph == 3 && i == 30) drain();
				if ($urandom_range(0, 3) == 0) idle_gap();
				send_vert(v);
			end
			// close any open triangle so the phase ends idle
			while (held_cnt != 0) send_vert(rand_vert(2));
			drain();
		end
		all_sent = 1'b1;

		$display("covered %0d triangles, %0d of them cut, %0d vertices out",
			n_tri, n_clipped, n_out);
		$display("planes: reset, zero normal, extreme and random; one long output stall");
		if (n_err == 0 && clip_q.size() == 0)
			$display("triangle_plane_clipper verification clean");
		else begin
			$display("%0d mismatches, %0d vertices left over", n_err, clip_q.size());
			$display("triangle_plane_clipper verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
